// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms; define ASSERT_OFF to compile them away.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// consequent must hold in the same cycle as the antecedent
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_SAME(label, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

// ===== design/msixvt_pkg.sv =====
// ----------------------------------------------------------------------------
// msixvt_pkg
// Types, codes and widths shared by the MSI-X vector table block.
// ----------------------------------------------------------------------------
`default_nettype none

package msixvt_pkg;

    // default table depth
    localparam int MAX_ENTRIES_DEF = 64;

    // stream payload widths
    localparam int S_TDATA_W = 120;
    localparam int S_TUSER_W = 1;
    localparam int M_TDATA_W = 88;
    localparam int M_TUSER_W = 1;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;

    localparam logic [CFG_IDX_W-1:0] CFG_TABLE_BASE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PENDING_BASE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_COUNT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TABLE_ON     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PENDING_ON   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MSIX_EN      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_FUNC_MASK    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_HW_DOMAIN    = 3'd7;

    // dword offset inside one 16-byte table entry
    localparam logic [1:0] OFF_ADDR_LO = 2'd0;
    localparam logic [1:0] OFF_ADDR_HI = 2'd1;
    localparam logic [1:0] OFF_DATA    = 2'd2;
    localparam logic [1:0] OFF_CTRL    = 2'd3;

    // result action codes
    typedef enum logic [2:0] {
        ACT_NONE      = 3'd0,
        ACT_REPROGRAM = 3'd1,
        ACT_MASK      = 3'd2,
        ACT_UNMASK    = 3'd3,
        ACT_FWD_READ  = 3'd4,
        ACT_FWD_WRITE = 3'd5
    } action_t;

    // decoded class of one access
    typedef enum logic [2:0] {
        ACC_RETRY,
        ACC_REJECT,
        ACC_PBA_READ,
        ACC_PBA_WRITE,
        ACC_PBA_DROP,
        ACC_TABLE
    } acc_kind_t;

    // controller states
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } ctrl_state_t;

    // one stored table entry
    typedef struct packed {
        logic        changed;
        logic        masked;
        logic [31:0] data;
        logic [63:0] addr;
    } vec_entry_t;

    localparam vec_entry_t ENTRY_INIT = '{changed: 1'b0, masked: 1'b1,
                                          data: 32'd0, addr: 64'd0};

    // controller to datapath
    typedef struct packed {
        logic clear_step;
        logic accept;
        logic exec;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clear_last;
        logic out_busy;
    } dp_stat_t;

endpackage

`default_nettype wire

// ===== design/msixvt_ram.sv =====
// ----------------------------------------------------------------------------
// msixvt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module msixvt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic                                     clk,
    input  wire logic                                     we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                         wdata,
    input  wire logic                                     re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== design/msixvt_ctrl.sv =====
// ----------------------------------------------------------------------------
// msixvt_ctrl
// Sequencer: clearing pass, word accept, entry update and result load.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module msixvt_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire msixvt_pkg::dp_stat_t stat,
    output msixvt_pkg::dp_cmd_t       cmd
);

    import msixvt_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (stat.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (!stat.out_busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        s_tready       = 1'b0;
        cmd.clear_step = 1'b0;
        cmd.accept     = 1'b0;
        cmd.exec       = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
            end
            ST_IDLE:
            begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
            end
            ST_EXEC:
            begin
                cmd.exec = !stat.out_busy;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    `ASSERT_NEXT(a_accept_to_exec, clk, rst_n, s_tvalid && s_tready, state_reg == ST_EXEC, "accepted word did not move to update")
    `ASSERT_NEXT(a_clear_ends, clk, rst_n, (state_reg == ST_CLEAR) && stat.clear_last, state_reg == ST_IDLE, "clearing pass did not end")
    `ASSERT_NEXT(a_exec_holds, clk, rst_n, (state_reg == ST_EXEC) && stat.out_busy, state_reg == ST_EXEC, "update left while result stalled")

endmodule

`default_nettype wire

// ===== design/msixvt_dp.sv =====
// ----------------------------------------------------------------------------
// msixvt_dp
// Datapath: configuration registers, address decode, entry RAM and result.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module msixvt_dp #(
    parameter int MAX_ENTRIES = msixvt_pkg::MAX_ENTRIES_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_wr_en,
    input  wire logic [msixvt_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [msixvt_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  wire logic [msixvt_pkg::S_TDATA_W-1:0]   s_tdata,
    input  wire logic [msixvt_pkg::S_TUSER_W-1:0]   s_tuser,
    input  wire logic                               m_tready,
    output logic                                    m_tvalid,
    output logic      [msixvt_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic      [msixvt_pkg::M_TUSER_W-1:0]   m_tuser,
    input  wire msixvt_pkg::dp_cmd_t                cmd,
    output msixvt_pkg::dp_stat_t                    stat
);

    import msixvt_pkg::*;

    localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam logic [6:0] NCAP = 7'((MAX_ENTRIES > 127) ? 127 : MAX_ENTRIES);
    localparam logic [IW-1:0] LAST_IDX = IW'(MAX_ENTRIES - 1);
    localparam int EW = $bits(vec_entry_t);

    // configuration registers
    logic [47:0] table_base_reg;
    logic [47:0] pending_base_reg;
    logic [6:0]  entry_count_reg;
    logic        table_on_reg;
    logic        pending_on_reg;
    logic        msix_en_reg;
    logic        func_mask_reg;
    logic        hw_domain_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_base_reg   <= '0;
            pending_base_reg <= '0;
            entry_count_reg  <= 7'd1;
            table_on_reg     <= 1'b0;
            pending_on_reg   <= 1'b0;
            msix_en_reg      <= 1'b0;
            func_mask_reg    <= 1'b0;
            hw_domain_reg    <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_TABLE_BASE:   table_base_reg   <= cfg_wdata[47:0];
                CFG_PENDING_BASE: pending_base_reg <= cfg_wdata[47:0];
                CFG_ENTRY_COUNT:  entry_count_reg  <= cfg_wdata[6:0];
                CFG_TABLE_ON:     table_on_reg     <= cfg_wdata[0];
                CFG_PENDING_ON:   pending_on_reg   <= cfg_wdata[0];
                CFG_MSIX_EN:      msix_en_reg      <= cfg_wdata[0];
                CFG_FUNC_MASK:    func_mask_reg    <= cfg_wdata[0];
                CFG_HW_DOMAIN:    hw_domain_reg    <= cfg_wdata[0];
                default:          table_base_reg   <= table_base_reg;
            endcase
        end
    end

    // input word fields
    logic        in_mode;
    logic [47:0] in_addr;
    logic [3:0]  in_size;
    logic [63:0] in_wval;

    assign in_mode = s_tuser[0];
    assign in_addr = s_tdata[47:0];
    assign in_size = s_tdata[51:48];
    assign in_wval = s_tdata[115:52];

    // window spans from the clamped entry count
    logic [6:0]  n_ent;
    logic [10:0] tlen;
    logic [4:0]  plen;
    logic [48:0] diff_t;
    logic [48:0] diff_p;
    logic        in_t;
    logic        in_p;
    logic        hit;
    logic        size_ok;
    acc_kind_t   kind_dec;

    assign n_ent  = (entry_count_reg > NCAP) ? NCAP : entry_count_reg;
    assign tlen   = {n_ent, 4'b0000};
    assign plen   = (n_ent > 7'd64) ? 5'd16 : ((n_ent != 7'd0) ? 5'd8 : 5'd0);
    assign diff_t = {1'b0, in_addr} - {1'b0, table_base_reg};
    assign diff_p = {1'b0, in_addr} - {1'b0, pending_base_reg};
    assign in_t   = !diff_t[48] && (diff_t[47:11] == '0) && (diff_t[10:0] < tlen);
    assign in_p   = !diff_p[48] && (diff_p[47:5] == '0) && (diff_p[4:0] < plen);
    assign hit    = (table_on_reg && in_t) || (pending_on_reg && in_p);
    assign size_ok = ((in_size == 4'd4) && (in_addr[1:0] == 2'b00))
                  || ((in_size == 4'd8) && (in_addr[2:0] == 3'b000));

    // classify the access
    always_comb
    begin
        if (!hit)
        begin
            kind_dec = ACC_RETRY;
        end
        else if (!size_ok)
        begin
            kind_dec = ACC_REJECT;
        end
        else if (in_p)
        begin
            if (!in_mode)
            begin
                kind_dec = ACC_PBA_READ;
            end
            else if (hw_domain_reg)
            begin
                kind_dec = ACC_PBA_WRITE;
            end
            else
            begin
                kind_dec = ACC_PBA_DROP;
            end
        end
        else
        begin
            kind_dec = ACC_TABLE;
        end
    end

    // latched access
    acc_kind_t   kind_reg;
    logic        wr_reg;
    logic        len8_reg;
    logic [1:0]  off_reg;
    logic [5:0]  ent_no_reg;
    logic [IW-1:0] ram_idx_reg;
    logic [7:0]  poff_reg;
    logic [63:0] wval_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            kind_reg    <= kind_dec;
            wr_reg      <= in_mode;
            len8_reg    <= (in_size == 4'd8);
            off_reg     <= in_addr[3:2];
            ent_no_reg  <= diff_t[9:4];
            ram_idx_reg <= IW'(diff_t[10:4]);
            poff_reg    <= diff_p[7:0];
            wval_reg    <= in_wval;
        end
    end

    // clearing pass counter
    logic [IW-1:0] clr_cnt_reg;
    logic [IW-1:0] clr_cnt_next;

    assign clr_cnt_next = cmd.clear_step ? (clr_cnt_reg + 1'b1) : clr_cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else
        begin
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    // entry RAM
    logic          ram_we;
    logic [IW-1:0] ram_waddr;
    logic [EW-1:0] ram_wdata;
    logic [EW-1:0] ram_rdata;
    vec_entry_t    cur;
    vec_entry_t    upd;
    logic          upd_we;

    msixvt_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_ENTRIES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (cmd.accept),
        .raddr (IW'(diff_t[10:4])),
        .rdata (ram_rdata)
    );

    assign cur       = vec_entry_t'(ram_rdata);
    assign ram_we    = cmd.clear_step || (cmd.exec && upd_we);
    assign ram_waddr = cmd.clear_step ? clr_cnt_reg : ram_idx_reg;
    assign ram_wdata = cmd.clear_step ? EW'(ENTRY_INIT) : EW'(upd);

    // result and entry update
    logic        res_status;
    logic [63:0] res_rv;
    action_t     res_act;
    logic [5:0]  res_ent;
    logic [7:0]  res_poff;

    always_comb
    begin
        logic [63:0] v;
        logic        ctrl;
        logic        nm;
        res_status = 1'b0;
        res_rv     = wr_reg ? 64'd0 : '1;
        res_act    = ACT_NONE;
        res_ent    = 6'd0;
        res_poff   = 8'd0;
        upd        = cur;
        upd_we     = 1'b0;
        v          = 64'd0;
        ctrl       = 1'b0;
        nm         = 1'b0;
        case (kind_reg)
            ACC_RETRY:
            begin
                res_status = 1'b1;
            end
            ACC_PBA_READ:
            begin
                res_act  = ACT_FWD_READ;
                res_poff = poff_reg;
            end
            ACC_PBA_WRITE:
            begin
                res_act  = ACT_FWD_WRITE;
                res_poff = poff_reg;
            end
            ACC_TABLE:
            begin
                res_ent = ent_no_reg;
                if (!wr_reg)
                begin
                    // read one word of the entry
                    case (off_reg)
                        OFF_ADDR_LO: v = cur.addr;
                        OFF_ADDR_HI: v = {32'd0, cur.addr[63:32]};
                        OFF_DATA:    v = {31'd0, len8_reg && cur.masked, cur.data};
                        default:     v = {63'd0, cur.masked};
                    endcase
                    res_rv = len8_reg ? v : {32'd0, v[31:0]};
                end
                else
                begin
                    // write one word, then apply any mask change
                    upd_we = 1'b1;
                    case (off_reg)
                        OFF_ADDR_LO:
                        begin
                            upd.changed = 1'b1;
                            upd.addr    = len8_reg ? wval_reg
                                                   : {cur.addr[63:32], wval_reg[31:0]};
                        end
                        OFF_ADDR_HI:
                        begin
                            upd.changed = 1'b1;
                            upd.addr    = {wval_reg[31:0], cur.addr[31:0]};
                        end
                        OFF_DATA:
                        begin
                            upd.changed = 1'b1;
                            upd.data    = wval_reg[31:0];
                            ctrl        = len8_reg;
                            nm          = wval_reg[32];
                        end
                        default:
                        begin
                            ctrl = 1'b1;
                            nm   = wval_reg[0];
                        end
                    endcase
                    if (ctrl && (cur.masked != nm))
                    begin
                        upd.masked = nm;
                        if (!nm && msix_en_reg && !func_mask_reg && upd.changed)
                        begin
                            res_act     = ACT_REPROGRAM;
                            upd.changed = 1'b0;
                        end
                        else
                        begin
                            res_act = nm ? ACT_MASK : ACT_UNMASK;
                        end
                    end
                end
            end
            default:
            begin
                res_status = 1'b0;
            end
        endcase
    end

    // output register
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [M_TDATA_W-1:0] out_data_reg;
    logic                 out_status_reg;

    assign out_valid_next = cmd.exec ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            out_data_reg   <= {7'd0, res_poff, res_ent, res_act, res_rv};
            out_status_reg <= res_status;
        end
    end

    assign m_tvalid        = out_valid_reg;
    assign m_tdata         = out_data_reg;
    assign m_tuser         = out_status_reg;
    assign stat.out_busy   = out_valid_reg && !m_tready;
    assign stat.clear_last = (clr_cnt_reg == LAST_IDX);

    `ASSERT_NEXT(a_exec_loads, clk, rst_n, cmd.exec, m_tvalid, "update did not present a result")
    `ASSERT_SAME(a_reprogram_entry, clk, rst_n, cmd.exec && (res_act == ACT_REPROGRAM), ram_we && !upd.masked && !upd.changed, "reprogram without unmasked, cleared entry")
    `ASSERT_SAME(a_no_clear_overlap, clk, rst_n, cmd.clear_step, !cmd.exec && !cmd.accept, "clearing pass overlaps an access")

endmodule

`default_nettype wire

// ===== design/msix_vector_table_registers.sv =====
// ----------------------------------------------------------------------------
// msix_vector_table_registers
// MSI-X vector table and pending bit array window on a stream access port.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over the entry RAM, one entry a
// cycle for all MAX_ENTRIES entries, with s_tready low; configuration
// writes are taken throughout. Then access words are taken one at a time:
// the entry is read from the RAM in the accept cycle and updated and written
// back in the update state, when the result word is loaded into the output
// register. A result that is not taken stalls the update of the following
// word only; the next word is still accepted while a result waits.
`default_nettype none

module msix_vector_table_registers #(
    parameter int MAX_ENTRIES = msixvt_pkg::MAX_ENTRIES_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // configuration writes
    input  wire logic                              cfg_wr_en,
    input  wire logic [msixvt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [msixvt_pkg::CFG_DATA_W-1:0] cfg_wdata,
    // access words
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // address[47:0], size_bytes[51:48], write_value[115:52], zero fill
    input  wire logic [msixvt_pkg::S_TDATA_W-1:0]  s_tdata,
    // mode[0]
    input  wire logic [msixvt_pkg::S_TUSER_W-1:0]  s_tuser,
    // result words
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // read_value[63:0], action[66:64], entry_number[72:67],
    // pending_offset[80:73], zero fill
    output logic      [msixvt_pkg::M_TDATA_W-1:0]  m_tdata,
    // status[0]
    output logic      [msixvt_pkg::M_TUSER_W-1:0]  m_tuser
);

    import msixvt_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    msixvt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    msixvt_dp #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

`default_nettype wire
